// ----- rtl/core/bdq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the bounded deque with remove-matching.
// No dependencies; imported by the deque top level.
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 32;

  // Command codes carried in the func field.
  localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [2:0] FUNC_INS_BACK  = 3'd1;
  localparam logic [2:0] FUNC_LIST      = 3'd2;
  localparam logic [2:0] FUNC_REMOVE    = 3'd3;
  localparam logic [2:0] FUNC_CLEAR     = 3'd4;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  localparam logic [5:0] REMOVED_MAX = 6'd63;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item;
    logic [5:0]         removed_count;
    logic               last;
  } out_beat_t;

endpackage

// ----- rtl/core/bounded_deque_remove_matching_top.sv -----
`timescale 1ns / 1ps
// Bounded deque of signed 32-bit values with insert, list, remove-matching and clear.
// Depends on bdq_pkg and bdq_ram.
//
// Usage: one command beat enters on in_valid/in_stall and carries func and value.
// Each command produces one result beat on out_valid/out_stall, except list, which
// gives one beat per stored entry from front to back when not empty, and the unused
// func codes, which give none. The last field marks the final beat of a command.
// Timing: a single-result beat passes from the accepting IDLE state through EXEC and
// RESP into the output register. A list reads its first entry in EXEC and then moves
// one entry per cycle into the output register while the output is not stalled; a
// remove walks all stored entries, one per cycle, through the RAM's read port and then
// hands its result through RESP to the output register. One command is handled at a
// time; the walk of a list or a remove is set by the single read port of the entry RAM.
// Reset clears the head pointer, entry count and output valid; the RAM is not cleared
// because only live entries are ever read. A stall on the result side freezes the
// output register and, during a list, the RAM read; the input is stalled until the
// current command has handed its last beat to the output register.
module bounded_deque_remove_matching_top
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_LIST   = 5'b00100,
    S_REMOVE = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         func_r, func_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      iss_r, iss_nxt;
  logic [CW-1:0]      kept_r, kept_nxt;
  out_beat_t          pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_beat_r, out_beat_nxt;

  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;
  logic [CW-1:0]      rd_off;
  logic [IW-1:0]      front_pos, back_pos, kept_pos;
  logic               out_free, full, empty, keep;
  logic [CW-1:0]      kept_new, removed;
  logic [7:0]         removed_wide;

  // Ring position of an offset from the head; the sum stays below twice DEPTH.
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + (IW+1)'(off);
    if (sum >= (IW+1)'(DEPTH)) begin
      sum = sum - (IW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  bdq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign front_pos = (head_r == '0) ? IW'(DEPTH - 1) : head_r - IW'(1);
  assign back_pos  = ring_add(head_r, count_r);
  assign kept_pos  = ring_add(head_r, kept_r);
  assign ram_raddr = ring_add(head_r, rd_off);

  // Compaction: a surviving entry goes to the next kept slot, which never lies
  // ahead of the read position, so no unread entry is overwritten.
  assign keep         = ($signed(ram_rdata) != value_r);
  assign kept_new     = kept_r + CW'(keep);
  assign removed      = count_r - kept_new;
  assign removed_wide = 8'(removed);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    value_nxt     = value_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    iss_nxt       = iss_r;
    kept_nxt      = kept_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = back_pos;
    ram_wdata     = value_r;
    rd_off        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_beat.func;
          value_nxt = in_beat.value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        pend_nxt      = '0;
        pend_nxt.last = 1'b1;
        state_nxt     = S_RESP;
        case (func_r)
          FUNC_INS_FRONT: begin
            if (full) begin
              pend_nxt.status = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = front_pos;
              head_nxt  = front_pos;
              count_nxt = count_r + CW'(1);
            end
          end
          FUNC_INS_BACK: begin
            if (full) begin
              pend_nxt.status = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = back_pos;
              count_nxt = count_r + CW'(1);
            end
          end
          FUNC_LIST: begin
            if (empty) begin
              pend_nxt.status = STAT_EMPTY;
            end else begin
              ram_re    = 1'b1;
              iss_nxt   = CW'(1);
              state_nxt = S_LIST;
            end
          end
          FUNC_REMOVE: begin
            if (empty) begin
              pend_nxt.status = STAT_EMPTY;
            end else begin
              ram_re    = 1'b1;
              iss_nxt   = CW'(1);
              kept_nxt  = '0;
              state_nxt = S_REMOVE;
            end
          end
          FUNC_CLEAR: begin
            if (empty) begin
              pend_nxt.status = STAT_EMPTY;
            end else begin
              count_nxt = '0;
              head_nxt  = '0;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_LIST: begin
        // The RAM output holds entry iss_r - 1; it is only advanced when that
        // entry has moved into the output register.
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_beat_nxt.status        = STAT_OK;
          out_beat_nxt.item          = $signed(ram_rdata);
          out_beat_nxt.removed_count = '0;
          out_beat_nxt.last          = (iss_r == count_r);
          if (iss_r != count_r) begin
            ram_re  = 1'b1;
            rd_off  = iss_r;
            iss_nxt = iss_r + CW'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_REMOVE: begin
        if (keep) begin
          ram_we    = 1'b1;
          ram_waddr = kept_pos;
          ram_wdata = ram_rdata;
        end
        if (iss_r != count_r) begin
          ram_re   = 1'b1;
          rd_off   = iss_r;
          iss_nxt  = iss_r + CW'(1);
          kept_nxt = kept_new;
        end else begin
          count_nxt     = kept_new;
          pend_nxt      = '0;
          pend_nxt.last = 1'b1;
          if (removed == '0) begin
            pend_nxt.status = STAT_NOT_FOUND;
          end else begin
            pend_nxt.status = STAT_OK;
          end
          if (removed_wide > 8'(REMOVED_MAX)) begin
            pend_nxt.removed_count = REMOVED_MAX;
          end else begin
            pend_nxt.removed_count = removed_wide[5:0];
          end
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = pend_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    value_r    <= value_nxt;
    iss_r      <= iss_nxt;
    kept_r     <= kept_nxt;
    pend_r     <= pend_nxt;
    out_beat_r <= out_beat_nxt;
  end

endmodule

// ----- rtl/core/bdq_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
